FILE: design/ctpk_pkg.sv
// Package: types, constants and tables for the cartesian to polar kinematics pipeline.
`timescale 1ns / 1ps
package ctpk_pkg;

	localparam int CW = 32;
	localparam int FB = 16;
	localparam int NST = 24;
	localparam int SQN = CW;
	localparam int RADW = 2 * CW;
	localparam int ZW = 36;
	localparam int SCALE_SH = 60 - CW;
	localparam int RND_SH = 30 - FB;
	localparam int RS = 47;

	localparam longint TWO_PI_Q32 = 64'sd26986075408;
	localparam longint TURN = (TWO_PI_Q32 + (64'sd1 <<< (31 - FB))) >>> (32 - FB);
	localparam longint RECIP = (64'sd1 <<< RS) / TURN;
	localparam longint HALF_PI_Q30 = 64'sd1686629713;

	localparam logic [31:0] ATAN_Q30 [0:31] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
		32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
		32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
		32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
		32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
		32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
		32'h00000001, 32'h00000000
	};

	typedef struct packed {
		logic signed [CW-1:0] x_target;
		logic                 x_valid;
		logic signed [CW-1:0] y_target;
		logic                 y_valid;
		logic signed [CW-1:0] z_target;
		logic signed [CW-1:0] x_current;
		logic signed [CW-1:0] y_current;
		logic signed [CW-1:0] angle_current;
	} cmd_t;

	typedef struct packed {
		logic        [CW-1:0] radius_out;
		logic signed [CW-1:0] angle_out;
		logic signed [CW-1:0] height_out;
		logic signed [CW-1:0] x_used;
		logic signed [CW-1:0] y_used;
	} res_t;

	typedef struct packed {
		logic                 org;
		logic signed [CW-1:0] xu;
		logic signed [CW-1:0] yu;
		logic signed [CW-1:0] h;
		logic signed [CW-1:0] cur;
		logic signed [63:0]   cx;
		logic signed [63:0]   cy;
		logic signed [ZW-1:0] cz;
		logic [RADW-1:0]      rad;
		logic [CW+3:0]        rem;
		logic [CW-1:0]        root;
	} pst_t;

endpackage

FILE: design/cartesian_to_polar_kinematics.sv
// Top level: pipelined cartesian to polar conversion with CORDIC angle and digit-serial root.
//
//  channel   ports                 transfer
//  command   start, busy, cmd      rising edge with start high and busy low
//  result    done, res             the single cycle done is high
//
// One command may enter every cycle; busy stays low.
// Stages: input, squares, sum, 32 root stages (the first NST also rotate CORDIC), 6 unwrap stages.
// The root stages retire one result bit each and set the depth.
// Reset clears only the valid bits; data registers hold stale values.
// The receiver cannot stall, so nothing is held back.
`timescale 1ns / 1ps
module cartesian_to_polar_kinematics (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  ctpk_pkg::cmd_t  cmd,
	output logic            done,
	output ctpk_pkg::res_t  res
);
	import ctpk_pkg::*;

	function automatic pst_t do_step(input pst_t a, input int k);
		pst_t o;
		logic [CW+3:0] rem2;
		logic [CW+3:0] trial;
		o = a;
		rem2 = {a.rem[CW+1:0], a.rad[RADW-1 -: 2]};
		trial = {2'b00, a.root, 2'b01};
		if (rem2 >= trial) begin
			o.rem = rem2 - trial;
			o.root = {a.root[CW-2:0], 1'b1};
		end else begin
			o.rem = rem2;
			o.root = {a.root[CW-2:0], 1'b0};
		end
		o.rad = {a.rad[RADW-3:0], 2'b00};
		if (k < NST) begin
			if (a.cy >= 0) begin
				o.cx = a.cx + (a.cy >>> k);
				o.cy = a.cy - (a.cx >>> k);
				o.cz = a.cz + ZW'($signed({1'b0, ATAN_Q30[k]}));
			end else begin
				o.cx = a.cx - (a.cy >>> k);
				o.cy = a.cy + (a.cx >>> k);
				o.cz = a.cz - ZW'($signed({1'b0, ATAN_Q30[k]}));
			end
		end
		return o;
	endfunction

	localparam logic signed [ZW-1:0] HP = ZW'(HALF_PI_Q30);
	localparam logic signed [CW+4:0] TURN_W = (CW+5)'(TURN);
	localparam logic [29:0] RECIP_W = 30'(RECIP);
	localparam logic [18:0] TURN_U = 19'(TURN);

	// stage 1: fill missing coordinates
	logic vld_s1;
	logic signed [CW-1:0] x_s1, y_s1, h_s1, cur_s1;

	// stage 2: squares and pre-rotation
	logic vld_s2;
	logic [63:0] sqx_s2, sqy_s2;
	logic signed [63:0] cx_s2, cy_s2;
	logic signed [ZW-1:0] cz_s2;
	logic org_s2;
	logic signed [CW-1:0] x_s2, y_s2, h_s2, cur_s2;

	// stage 3: radicand
	logic vld_s3;
	pst_t p_s3;

	logic [SQN-1:0] vld_it_s;
	pst_t it_s [SQN];

	logic vld_s36;
	logic [CW-1:0] rad_s36;
	logic signed [ZW-1:0] th_s36;
	logic signed [CW-1:0] cur_s36, h_s36, x_s36, y_s36;

	logic vld_s37;
	logic [1:0] mode_s37;
	logic [33:0] n_s37;
	logic [CW-1:0] rad_s37;
	logic signed [ZW-1:0] th_s37;
	logic signed [CW-1:0] cur_s37, h_s37, x_s37, y_s37;

	logic vld_s38;
	logic [63:0] prod_s38;
	logic [1:0] mode_s38;
	logic [33:0] n_s38;
	logic [CW-1:0] rad_s38;
	logic signed [ZW-1:0] th_s38;
	logic signed [CW-1:0] cur_s38, h_s38, x_s38, y_s38;

	logic vld_s39;
	logic [34:0] qt_s39;
	logic [1:0] mode_s39;
	logic [33:0] n_s39;
	logic [CW-1:0] rad_s39;
	logic signed [ZW-1:0] th_s39;
	logic signed [CW-1:0] cur_s39, h_s39, x_s39, y_s39;

	logic vld_s40;
	logic [33:0] r_s40;
	logic [1:0] mode_s40;
	logic [CW-1:0] rad_s40;
	logic signed [ZW-1:0] th_s40;
	logic signed [CW-1:0] cur_s40, h_s40, x_s40, y_s40;

	logic done_q;
	res_t res_q;

	localparam logic [1:0] M_KEEP = 2'd0;
	localparam logic [1:0] M_DOWN = 2'd1;
	localparam logic [1:0] M_UP = 2'd2;

	logic [CW-1:0] mx, my;
	logic signed [63:0] xs, ys;
	logic [CW:0] root_r;
	logic signed [ZW-1:0] th_r;
	logic signed [CW+4:0] d_c;
	logic [34:0] r_c;
	logic signed [CW+4:0] fin_c;
	logic signed [CW-1:0] sat_c;

	assign busy = 1'b0;
	assign mx = x_s1[CW-1] ? CW'(-x_s1) : CW'(x_s1);
	assign my = y_s1[CW-1] ? CW'(-y_s1) : CW'(y_s1);
	assign xs = {{(64-CW-SCALE_SH){x_s1[CW-1]}}, x_s1, {SCALE_SH{1'b0}}};
	assign ys = {{(64-CW-SCALE_SH){y_s1[CW-1]}}, y_s1, {SCALE_SH{1'b0}}};

	always_comb begin
		root_r = {1'b0, it_s[SQN-1].root};
		if (it_s[SQN-1].rem > {4'b0000, it_s[SQN-1].root})
			root_r = root_r + 1'b1;
		th_r = (it_s[SQN-1].cz + (ZW'(1) <<< (RND_SH - 1))) >>> RND_SH;
		d_c = (CW+5)'(th_s36) - (CW+5)'(cur_s36);
		r_c = {1'b0, n_s39} - qt_s39;
		if (r_c >= {16'd0, TURN_U})
			r_c = r_c - {16'd0, TURN_U};
		case (mode_s40)
			M_DOWN:  fin_c = (CW+5)'(cur_s40) + 1 + (CW+5)'($signed({1'b0, r_s40}));
			M_UP:    fin_c = (CW+5)'(cur_s40) - 1 - (CW+5)'($signed({1'b0, r_s40}));
			default: fin_c = (CW+5)'(th_s40);
		endcase
		if (fin_c > $signed((CW+5)'({1'b0, {(CW-1){1'b1}}})))
			sat_c = {1'b0, {(CW-1){1'b1}}};
		else if (fin_c < -$signed((CW+5)'({1'b1, {(CW-1){1'b0}}})))
			sat_c = {1'b1, {(CW-1){1'b0}}};
		else
			sat_c = fin_c[CW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_it_s <= '0;
			vld_s36 <= 1'b0;
			vld_s37 <= 1'b0;
			vld_s38 <= 1'b0;
			vld_s39 <= 1'b0;
			vld_s40 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_it_s <= {vld_it_s[SQN-2:0], vld_s3};
			vld_s36 <= vld_it_s[SQN-1];
			vld_s37 <= vld_s36;
			vld_s38 <= vld_s37;
			vld_s39 <= vld_s38;
			vld_s40 <= vld_s39;
			done_q <= vld_s40;
		end
	end

	always_ff @(posedge clk) begin
		x_s1 <= cmd.x_valid ? cmd.x_target : cmd.x_current;
		y_s1 <= cmd.y_valid ? cmd.y_target : cmd.y_current;
		h_s1 <= cmd.z_target;
		cur_s1 <= cmd.angle_current;

		sqx_s2 <= 64'(mx) * 64'(mx);
		sqy_s2 <= 64'(my) * 64'(my);
		org_s2 <= (x_s1 == '0) && (y_s1 == '0);
		if (x_s1[CW-1]) begin
			if (!y_s1[CW-1]) begin
				cx_s2 <= ys;
				cy_s2 <= -xs;
				cz_s2 <= HP;
			end else begin
				cx_s2 <= -ys;
				cy_s2 <= xs;
				cz_s2 <= -HP;
			end
		end else begin
			cx_s2 <= xs;
			cy_s2 <= ys;
			cz_s2 <= '0;
		end
		x_s2 <= x_s1;
		y_s2 <= y_s1;
		h_s2 <= h_s1;
		cur_s2 <= cur_s1;

		p_s3.org <= org_s2;
		p_s3.xu <= x_s2;
		p_s3.yu <= y_s2;
		p_s3.h <= h_s2;
		p_s3.cur <= cur_s2;
		p_s3.cx <= cx_s2;
		p_s3.cy <= cy_s2;
		p_s3.cz <= cz_s2;
		p_s3.rad <= sqx_s2 + sqy_s2;
		p_s3.rem <= '0;
		p_s3.root <= '0;

		for (int k = 0; k < SQN; k++)
			it_s[k] <= do_step((k == 0) ? p_s3 : it_s[(k == 0) ? 0 : k - 1], k);

		rad_s36 <= root_r[CW] ? {CW{1'b1}} : root_r[CW-1:0];
		th_s36 <= it_s[SQN-1].org ? '0 : th_r;
		cur_s36 <= it_s[SQN-1].cur;
		h_s36 <= it_s[SQN-1].h;
		x_s36 <= it_s[SQN-1].xu;
		y_s36 <= it_s[SQN-1].yu;

		if (d_c > TURN_W) begin
			mode_s37 <= M_DOWN;
			n_s37 <= 34'(d_c - 1);
		end else if (d_c < -TURN_W) begin
			mode_s37 <= M_UP;
			n_s37 <= 34'(-d_c - 1);
		end else begin
			mode_s37 <= M_KEEP;
			n_s37 <= '0;
		end
		rad_s37 <= rad_s36;
		th_s37 <= th_s36;
		cur_s37 <= cur_s36;
		h_s37 <= h_s36;
		x_s37 <= x_s36;
		y_s37 <= y_s36;

		prod_s38 <= 64'(n_s37) * 64'(RECIP_W);
		mode_s38 <= mode_s37;
		n_s38 <= n_s37;
		rad_s38 <= rad_s37;
		th_s38 <= th_s37;
		cur_s38 <= cur_s37;
		h_s38 <= h_s37;
		x_s38 <= x_s37;
		y_s38 <= y_s37;

		qt_s39 <= 35'(prod_s38[63:RS]) * 35'(TURN_U);
		mode_s39 <= mode_s38;
		n_s39 <= n_s38;
		rad_s39 <= rad_s38;
		th_s39 <= th_s38;
		cur_s39 <= cur_s38;
		h_s39 <= h_s38;
		x_s39 <= x_s38;
		y_s39 <= y_s38;

		r_s40 <= r_c[33:0];
		mode_s40 <= mode_s39;
		rad_s40 <= rad_s39;
		th_s40 <= th_s39;
		cur_s40 <= cur_s39;
		h_s40 <= h_s39;
		x_s40 <= x_s39;
		y_s40 <= y_s39;

		res_q.radius_out <= rad_s40;
		res_q.angle_out <= sat_c;
		res_q.height_out <= h_s40;
		res_q.x_used <= x_s40;
		res_q.y_used <= y_s40;
	end

	assign done = done_q;
	assign res = res_q;

endmodule

FILE: sim/testbench.sv
// Testbench for cartesian_to_polar_kinematics: directed table, then random commands.
`timescale 1ns / 1ps
module testbench;
	import ctpk_pkg::*;

	typedef struct {
		cmd_t c;
		bit   typed;
		res_t r;
	} row_t;

	logic clk, arst_n, start, busy, done;
	cmd_t cmd;
	res_t res;

	res_t pending_q[$];
	int errors = 0;
	int n_sent = 0;
	int n_done = 0;
	int cycles = 0;
	bit typed_next = 0;
	res_t typed_res;

	cartesian_to_polar_kinematics DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .done(done), .res(res)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic res_t polar_of(cmd_t c);
		longint x, y, xs, ys, z, t, dx, dy, th, d;
		longint unsigned sq, r, cand;
		res_t o;
		x = c.x_valid ? c.x_target : c.x_current;
		y = c.y_valid ? c.y_target : c.y_current;
		sq = longint'(x * x) + longint'(y * y);
		r = 0;
		for (int b = 31; b >= 0; b--) begin
			cand = r | (64'd1 << b);
			if (cand * cand <= sq) r = cand;
		end
		if (sq - r * r > r) r++;
		if (r > 64'hFFFF_FFFF) r = 64'hFFFF_FFFF;
		if (x == 0 && y == 0) th = 0;
		else begin
			xs = x * (64'sd1 <<< 28);
			ys = y * (64'sd1 <<< 28);
			z = 0;
			if (xs < 0) begin
				if (ys >= 0) begin
					t = xs; xs = ys; ys = -t; z = HALF_PI_Q30;
				end else begin
					t = xs; xs = -ys; ys = t; z = -HALF_PI_Q30;
				end
			end
			for (int i = 0; i < 24; i++) begin
				dx = ys >>> i;
				dy = xs >>> i;
				if (ys >= 0) begin
					xs += dx; ys -= dy; z += longint'(ATAN_Q30[i]);
				end else begin
					xs -= dx; ys += dy; z -= longint'(ATAN_Q30[i]);
				end
			end
			th = (z + (64'sd1 <<< 13)) >>> 14;
		end
		d = th - longint'(c.angle_current);
		if (d > TURN) th -= ((d - 1) / TURN) * TURN;
		else if (d < -TURN) th += ((-d - 1) / TURN) * TURN;
		if (th > 64'sd2147483647) th = 64'sd2147483647;
		if (th < -64'sd2147483648) th = -64'sd2147483648;
		o.radius_out = r[31:0];
		o.angle_out = th[31:0];
		o.height_out = c.z_target;
		o.x_used = x[31:0];
		o.y_used = y[31:0];
		return o;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h expected %h (result %0d)", what, got, want, n_done);
		errors++;
	endtask

	// transfer accounting on both channels
	always @(posedge clk) begin
		if (arst_n) begin
			cycles++;
			if (start && !busy) begin
				pending_q.push_back(typed_next ? typed_res : polar_of(cmd));
				n_sent++;
			end
			if (done) begin
				if (pending_q.size() == 0) begin
					$display("unexpected result at cycle %0d", cycles);
					errors++;
				end else begin
					res_t e;
					e = pending_q.pop_front();
					if (res.radius_out !== e.radius_out) report("radius", res.radius_out, e.radius_out);
					if (res.angle_out !== e.angle_out) report("angle", res.angle_out, e.angle_out);
					if (res.height_out !== e.height_out) report("height", res.height_out, e.height_out);
					if (res.x_used !== e.x_used) report("x_used", res.x_used, e.x_used);
					if (res.y_used !== e.y_used) report("y_used", res.y_used, e.y_used);
				end
				n_done++;
			end
			if (cycles > 200000) begin
				$display("FAIL cartesian_to_polar_kinematics");
				$finish;
			end
		end
	end

	function automatic cmd_t mk(int xt, bit xv, int yt, bit yv, int zt, int xc, int yc, int ac);
		cmd_t c;
		c.x_target = xt; c.x_valid = xv; c.y_target = yt; c.y_valid = yv;
		c.z_target = zt; c.x_current = xc; c.y_current = yc; c.angle_current = ac;
		return c;
	endfunction

	function automatic res_t mkr(int r, int a, int h, int xu, int yu);
		res_t o;
		o.radius_out = r; o.angle_out = a; o.height_out = h; o.x_used = xu; o.y_used = yu;
		return o;
	endfunction

	function automatic int rnd_coord();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $urandom_range(0, 2 * 1048576) - 1048576;
			2: return ($urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF) ^ $urandom_range(0, 255);
			default: return $urandom_range(0, 2 * 65536 * 500) - 65536 * 500;
		endcase
	endfunction

	task automatic send(cmd_t c, bit typed, res_t r, bit no_gap);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		typed_next <= typed;
		typed_res <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	initial begin
		row_t dir[$];
		cmd_t c;
		res_t none;
		int mx, mn, waited;
		bit burst;
		mx = 32'h7FFF_FFFF;
		mn = 32'h8000_0000;
		none = '0;
		arst_n = 0;
		start = 0;
		cmd = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		dir.push_back('{mk(0, 1, 0, 1, 42, 5, 6, 0), 1, mkr(0, 0, 42, 0, 0)});
		dir.push_back('{mk(7, 0, 9, 0, mn, 0, 0, 0), 1, mkr(0, 0, mn, 0, 0)});
		dir.push_back('{mk(0, 1, 0, 1, mx, 1, 1, mx), 1, mkr(0, (mx - 1) / 411775 * 411775, mx, 0, 0)});
		dir.push_back('{mk(65536, 1, 0, 1, 0, 0, 0, 0), 0, none});
		dir.push_back('{mk(-65536, 1, 0, 1, 0, 0, 0, 0), 0, none});
		dir.push_back('{mk(-65536, 1, -1, 1, 0, 0, 0, 0), 0, none});
		dir.push_back('{mk(0, 1, 65536, 1, 0, 0, 0, 0), 0, none});
		dir.push_back('{mk(0, 1, -65536, 1, 0, 0, 0, 0), 0, none});
		dir.push_back('{mk(mx, 1, mx, 1, mx, mn, mn, mn), 0, none});
		dir.push_back('{mk(mn, 1, mn, 1, mn, mx, mx, mx), 0, none});
		dir.push_back('{mk(mn, 1, 0, 1, 0, 0, 0, 0), 0, none});
		dir.push_back('{mk(mn, 1, -1, 1, 0, 0, 0, mx), 0, none});
		dir.push_back('{mk(0, 0, 3, 1, 1, mx, 0, mn), 0, none});
		dir.push_back('{mk(3, 1, 0, 0, 1, 0, mn, 0), 0, none});
		dir.push_back('{mk(1, 1, 1, 1, -1, 0, 0, 411775), 0, none});
		dir.push_back('{mk(1, 1, 1, 1, -1, 0, 0, 411775 * 2), 0, none});
		dir.push_back('{mk(1, 1, 1, 1, -1, 0, 0, -411775), 0, none});
		dir.push_back('{mk(-5, 1, 0, 1, 0, 0, 0, -411775 * 4), 0, none});
		dir.push_back('{mk(3, 1, 4, 1, 2, 0, 0, 0), 0, none});
		dir.push_back('{mk(mx, 0, mx, 0, 0, mn, mx, 0), 0, none});
		foreach (dir[i]) send(dir[i].c, dir[i].typed, dir[i].r, 0);

		burst = 0;
		for (int i = 0; i < 1400; i++) begin
			if (i % 100 == 0) burst = $urandom_range(0, 2) == 0;
			c.x_target = rnd_coord();
			c.y_target = rnd_coord();
			c.z_target = $urandom;
			c.x_current = rnd_coord();
			c.y_current = rnd_coord();
			c.x_valid = $urandom_range(0, 3) != 0;
			c.y_valid = $urandom_range(0, 3) != 0;
			case ($urandom_range(0, 2))
				0: c.angle_current = $urandom;
				1: c.angle_current = ($urandom_range(0, 10000) - 5000) * 411775
					+ $urandom_range(0, 8) - 4;
				default: c.angle_current = $urandom_range(0, 2000000) - 1000000;
			endcase
			send(c, 0, none, burst);
		end
		start <= 1'b0;
		typed_next <= 1'b0;

		waited = 0;
		while (pending_q.size() != 0 && waited < 10000) begin
			@(posedge clk);
			waited++;
		end
		repeat (60) @(posedge clk);
		$display("sent %0d commands (directed table and random, full-range and small coordinates)",
			n_sent);
		$display("checked %0d results against the predictor", n_done);
		if (errors == 0 && pending_q.size() == 0) begin
			$display("PASS cartesian_to_polar_kinematics");
		end else begin
			$display("FAIL cartesian_to_polar_kinematics");
		end
		$finish;
	end
endmodule
